// ----- rtl/bdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types, codes and widths for the bounded double-ended queue
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT     = 8;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int OCC_W    = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_LIST       = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic list_rd;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    empty;
      logic    list_end;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/bdq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/bdq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// command sequencer: accept, decode and list walk
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output bdq_pkg::ctl_type       ctl,
   input  wire bdq_pkg::stat_type st
);
   import bdq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LIST
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in    = state_ff;
      ctl.capture = 1'b0;
      ctl.exec    = 1'b0;
      ctl.list_rd = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctl.exec = 1'b1;
            if (st.cmd == CMD_LIST && !st.empty) begin
               state_in = ST_LIST;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            ctl.list_rd = 1'b1;
            if (st.list_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LIST |-> !st.empty)
      else $error("list walk on empty queue");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      !(ctl.exec && ctl.list_rd))
      else $error("decode and list read together");

   a_list_done: assert property (@(posedge clock) disable iff (reset)
      (ctl.list_rd && st.list_end) |=> !busy_ff)
      else $error("still busy after final list read");

endmodule
`default_nettype wire

// ----- rtl/bdq_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_datapath
// ring pointers, slot ram and result registers
// ----------------------------------------------------------------------------
module bdq_datapath #(
   parameter int DEPTH     = bdq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bdq_pkg::ctl_type                    ctl,
   output bdq_pkg::stat_type                        st,
   input  wire logic        [bdq_pkg::CMD_W-1:0]    req_command,
   input  wire logic signed [bdq_pkg::DATA_W-1:0]   req_push_value,
   output logic                                     rsp_strobe,
   output logic             [bdq_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [bdq_pkg::DATA_W-1:0]   rsp_data_value,
   output logic             [bdq_pkg::OCC_W-1:0]    rsp_occupancy,
   output logic                                     rsp_last
);
   import bdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type                  cmd_ff;
   logic [DATA_W-1:0]        value_ff;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     pend_ff, pend_in;
   logic                     pend_ram_ff, pend_ram_in;
   logic                     pend_last_ff, pend_last_in;
   status_type               pend_status_ff, pend_status_in;

   logic                     rsp_strobe_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_data_value_ff;
   logic [OCC_W-1:0]         rsp_occupancy_ff;
   logic                     rsp_last_ff;

   logic                     full, empty, list_end;
   logic [CNT_W-1:0]         count_m1, offset;
   logic [CNT_W:0]           head_wide, pos_sum, pos_wrap;
   logic [IDX_W-1:0]         ring_pos, head_dec, head_inc;
   logic                     we;
   logic [IDX_W-1:0]         waddr, raddr;
   logic [WORD_BITS-1:0]     wdata, rdata;
   logic [WORD_BITS+DATA_W-1:0] value_wide;
   logic [DATA_W+WORD_BITS-1:0] rd_wide;
   logic [OCC_W+CNT_W-1:0]   occ_wide;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count_m1 = count_ff - 1'b1;
   assign list_end = (idx_ff == count_m1);

   assign head_wide = {{(CNT_W + 1 - IDX_W){1'b0}}, head_ff};
   assign pos_sum   = head_wide + {1'b0, offset};
   assign pos_wrap  = (pos_sum >= (CNT_W + 1)'(DEPTH)) ? pos_sum - (CNT_W + 1)'(DEPTH) : pos_sum;
   assign ring_pos  = pos_wrap[IDX_W-1:0];
   assign head_dec  = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign value_wide = {{WORD_BITS{1'b0}}, value_ff};
   assign wdata      = value_wide[WORD_BITS-1:0];
   assign rd_wide    = {{DATA_W{1'b0}}, rdata};
   assign occ_wide   = {{OCC_W{1'b0}}, count_ff};

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      pend_ram_in    = 1'b0;
      pend_last_in   = 1'b1;
      pend_status_in = STATUS_OK;
      we             = 1'b0;
      offset         = '0;
      waddr          = ring_pos;
      raddr          = ring_pos;
      if (ctl.list_rd) begin
         offset       = idx_ff;
         idx_in       = idx_ff + 1'b1;
         pend_in      = 1'b1;
         pend_ram_in  = 1'b1;
         pend_last_in = list_end;
      end else if (ctl.exec) begin
         pend_in = 1'b1;
         case (cmd_ff)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  pend_status_in = STATUS_OVERFLOW;
               end else begin
                  we       = 1'b1;
                  waddr    = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               offset = count_ff;
               if (full) begin
                  pend_status_in = STATUS_OVERFLOW;
               end else begin
                  we       = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  pend_ram_in = 1'b1;
                  head_in     = head_inc;
                  count_in    = count_m1;
               end
            end
            CMD_POP_BACK: begin
               offset = count_m1;
               if (empty) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  pend_ram_in = 1'b1;
                  count_in    = count_m1;
               end
            end
            CMD_LIST: begin
               idx_in = '0;
               if (empty) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  pend_in = 1'b0;
               end
            end
            default: begin
               pend_status_in = STATUS_OK;
            end
         endcase
      end
   end

   bdq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= cmd_type'(req_command);
         value_ff <= req_push_value;
      end
      idx_ff         <= idx_in;
      pend_ram_ff    <= pend_ram_in;
      pend_last_ff   <= pend_last_in;
      pend_status_ff <= pend_status_in;
      if (pend_ff) begin
         rsp_status_ff     <= pend_status_ff;
         rsp_data_value_ff <= pend_ram_ff ? rd_wide[DATA_W-1:0] : '0;
         rsp_occupancy_ff  <= occ_wide[OCC_W-1:0];
         rsp_last_ff       <= pend_last_ff;
      end
   end

   assign st.cmd      = cmd_ff;
   assign st.empty    = empty;
   assign st.list_end = list_end;

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_value = rsp_data_value_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;
   assign rsp_last       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_wide < (CNT_W + 1)'(DEPTH))
      else $error("head index outside ring");

   a_pend_beat: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_strobe_ff)
      else $error("pending result lost");

endmodule
`default_nettype wire

// ----- rtl/bounded_double_ended_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// bounded deque of signed words held in a ring
// ----------------------------------------------------------------------------
// a command is taken at a rising edge with start high and busy low:
// req_command selects push front, push back, pop front, pop back or list,
// req_push_value is the word for pushes.
// each result beat shows on the rsp_ ports for one cycle with rsp_strobe;
// rsp_occupancy is the fill after the command, rsp_last marks its final beat.
// a push or pop gives one beat through the decode state, the pending flag
// and the result registers; busy is high only in decode, so the next
// command can be taken while that beat is still in flight. list walks the
// ring one slot ram read per cycle: a queue of n words gives n beats, one
// per cycle; busy stays high to the end of the walk. listing an empty queue gives one empty beat.
// reset empties the queue; slot contents are left as they are.
// the receiver cannot stall: beats must be taken as they come.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top #(
   parameter int DEPTH     = bdq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [bdq_pkg::CMD_W-1:0]    req_command,
   input  wire logic signed [bdq_pkg::DATA_W-1:0]   req_push_value,
   output logic                                     rsp_strobe,
   output logic             [bdq_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [bdq_pkg::DATA_W-1:0]   rsp_data_value,
   output logic             [bdq_pkg::OCC_W-1:0]    rsp_occupancy,
   output logic                                     rsp_last
);
   import bdq_pkg::*;

   ctl_type  ctl;
   stat_type st;

   bdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl),
      .st    (st)
   );

   bdq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .st             (st),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_data_value (rsp_data_value),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// checks the bounded deque beat by beat against an in-bench ring predictor
// ----------------------------------------------------------------------------
// a short table of directed commands comes first: the empty queue, word
// extremes, filling to overflow, the unused command codes, and listing a full
// and a wrapped ring. a random run follows. It alternates phases that fill and
// drain the queue so that full and empty are reached often. Every accepted
// command is applied to a ring model kept here. Each rsp_strobe beat is
// compared field by field with the oldest beat still due.
// ----------------------------------------------------------------------------
module testbench;
   import bdq_pkg::*;

   localparam int DEPTH           = DEPTH_DEFAULT;
   localparam int RANDOM_COMMANDS = 420;
   localparam int MAX_GAP         = 19;

   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic [OCC_W-1:0]         occ;
      logic                     last;
   } beat_type;

   typedef struct {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] value;
      bit                       typed;
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic [OCC_W-1:0]         occ;
   } step_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [CMD_W-1:0]         req_command = '0;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_data_value;
   logic [OCC_W-1:0]         rsp_occupancy;
   logic                     rsp_last;

   beat_type                 due_beats[$];
   int                       error_count = 0;

   // ring predictor state
   logic signed [DATA_W-1:0] ring_words [DEPTH];
   int                       front_slot = 0;
   int                       word_count = 0;

   int                       calm_left = 0;

   step_row_type directed_steps [] = '{
      '{CMD_POP_FRONT,  32'sh0,        1'b1, STATUS_EMPTY,    32'sh0,        4'd0},
      '{CMD_POP_BACK,   32'sh0,        1'b1, STATUS_EMPTY,    32'sh0,        4'd0},
      '{CMD_LIST,       32'sh0,        1'b1, STATUS_EMPTY,    32'sh0,        4'd0},
      '{CMD_SPARE_5,    32'shffffffff, 1'b1, STATUS_OK,       32'sh0,        4'd0},
      '{CMD_PUSH_FRONT, 32'sh7fffffff, 1'b1, STATUS_OK,       32'sh0,        4'd1},
      '{CMD_PUSH_BACK,  32'sh80000000, 1'b1, STATUS_OK,       32'sh0,        4'd2},
      '{CMD_PUSH_FRONT, 32'shffffffff, 1'b1, STATUS_OK,       32'sh0,        4'd3},
      '{CMD_PUSH_BACK,  32'sh0,        1'b1, STATUS_OK,       32'sh0,        4'd4},
      '{CMD_PUSH_FRONT, 32'sh1,        1'b1, STATUS_OK,       32'sh0,        4'd5},
      '{CMD_PUSH_BACK,  32'sh55555555, 1'b1, STATUS_OK,       32'sh0,        4'd6},
      '{CMD_PUSH_FRONT, 32'shaaaaaaaa, 1'b1, STATUS_OK,       32'sh0,        4'd7},
      '{CMD_PUSH_BACK,  32'sh12345678, 1'b1, STATUS_OK,       32'sh0,        4'd8},
      '{CMD_PUSH_FRONT, 32'sh7,        1'b1, STATUS_OVERFLOW, 32'sh0,        4'd8},
      '{CMD_PUSH_BACK,  32'sh9,        1'b1, STATUS_OVERFLOW, 32'sh0,        4'd8},
      '{CMD_LIST,       32'sh0,        1'b0, STATUS_OK,       32'sh0,        4'd0},
      '{CMD_SPARE_6,    32'sh0,        1'b1, STATUS_OK,       32'sh0,        4'd8},
      '{CMD_SPARE_7,    32'sh0,        1'b1, STATUS_OK,       32'sh0,        4'd8},
      '{CMD_POP_FRONT,  32'sh0,        1'b1, STATUS_OK,       32'shaaaaaaaa, 4'd7},
      '{CMD_POP_BACK,   32'sh0,        1'b1, STATUS_OK,       32'sh12345678, 4'd6},
      '{CMD_POP_FRONT,  32'sh0,        1'b0, STATUS_OK,       32'sh0,        4'd0},
      '{CMD_PUSH_BACK,  32'sh3,        1'b0, STATUS_OK,       32'sh0,        4'd0},
      '{CMD_PUSH_BACK,  32'sh4,        1'b0, STATUS_OK,       32'sh0,        4'd0},
      '{CMD_LIST,       32'sh0,        1'b0, STATUS_OK,       32'sh0,        4'd0},
      '{CMD_POP_BACK,   32'sh0,        1'b0, STATUS_OK,       32'sh0,        4'd0},
      '{CMD_LIST,       32'sh0,        1'b0, STATUS_OK,       32'sh0,        4'd0}
   };

   bounded_double_ended_queue_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_data_value (rsp_data_value),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic apply_deque_command(input logic [CMD_W-1:0] cmd,
                                      input logic signed [DATA_W-1:0] word,
                                      output beat_type beats[$]);
      beat_type b;
      beats    = {};
      b.status = STATUS_OK;
      b.data   = '0;
      b.last   = 1'b1;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (word_count == DEPTH) begin
               b.status = STATUS_OVERFLOW;
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  front_slot = (front_slot + DEPTH - 1) % DEPTH;
                  ring_words[front_slot] = word;
               end else begin
                  ring_words[(front_slot + word_count) % DEPTH] = word;
               end
               word_count++;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (word_count == 0) begin
               b.status = STATUS_EMPTY;
            end else if (cmd == CMD_POP_FRONT) begin
               b.data     = ring_words[front_slot];
               front_slot = (front_slot + 1) % DEPTH;
               word_count--;
            end else begin
               b.data = ring_words[(front_slot + word_count - 1) % DEPTH];
               word_count--;
            end
         end
         CMD_LIST: begin
            if (word_count == 0) begin
               b.status = STATUS_EMPTY;
            end else begin
               for (int i = 0; i < word_count; i++) begin
                  b.data = ring_words[(front_slot + i) % DEPTH];
                  b.occ  = OCC_W'(word_count);
                  b.last = (i == word_count - 1);
                  beats.push_back(b);
               end
            end
         end
         default: ;
      endcase
      if (beats.size() == 0) begin
         b.occ = OCC_W'(word_count);
         beats.push_back(b);
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_W-1:0] word,
                                input bit typed, input beat_type typed_beat);
      beat_type beats[$];
      start          <= 1'b1;
      req_command    <= cmd;
      req_push_value <= word;
      do @(posedge clock); while (busy !== 1'b0);
      apply_deque_command(cmd, word, beats);
      if (typed) begin
         due_beats.push_back(typed_beat);
      end else begin
         foreach (beats[i]) due_beats.push_back(beats[i]);
      end
      @(negedge clock);
   endtask

   task automatic idle_after_beat();
      int gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 5) == 0) begin
         calm_left = $urandom_range(8, 30);
         gap = 0;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      do @(negedge clock); while (due_beats.size() != 0);
   endtask

   task automatic check_field(input string what, input logic signed [DATA_W-1:0] want,
                              input logic signed [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch_beats
      beat_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (due_beats.size() == 0) begin
            $display("%0t: beat with none due, expected nothing actual status %0d data %0d",
                     $time, rsp_status, rsp_data_value);
            error_count++;
         end else begin
            want = due_beats.pop_front();
            check_field("status",    DATA_W'(want.status), DATA_W'(rsp_status));
            check_field("data",      want.data,            rsp_data_value);
            check_field("occupancy", DATA_W'(want.occ),    DATA_W'(rsp_occupancy));
            check_field("last",      DATA_W'(want.last),   DATA_W'(rsp_last));
         end
      end
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      beat_type                 typed_beat;
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] word;
      bit                       filling;
      int                       phase_left;
      int                       pick;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         typed_beat = '{directed_steps[i].status, directed_steps[i].data,
                        directed_steps[i].occ, 1'b1};
         issue_command(directed_steps[i].command, directed_steps[i].value,
                       directed_steps[i].typed, typed_beat);
         idle_after_beat();
      end
      hold_until_drained();

      filling    = 1'b1;
      phase_left = 0;
      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         // swing between filling and draining phases to hit full and empty
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(8, 30);
         end
         phase_left--;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            cmd = CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
         end else if (pick < 13) begin
            cmd = CMD_LIST;
         end else if (($urandom_range(0, 3) != 0) == filling) begin
            cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
         end
         case ($urandom_range(0, 9))
            0:       word = 32'sh7fffffff;
            1:       word = 32'sh80000000;
            default: word = $urandom;
         endcase
         issue_command(cmd, word, 1'b0, typed_beat);
         if (n == RANDOM_COMMANDS / 2) begin
            hold_until_drained();
         end else begin
            idle_after_beat();
         end
      end

      hold_until_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && due_beats.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
